@@ rtl/get_pkg.sv @@
`default_nettype none

package get_pkg;

  localparam int SLOT_PW     = 10;
  localparam int GEN_W       = 16;
  localparam int COORD_W     = 24;
  localparam int TEAM_W      = 4;
  localparam int RAD_W       = 23;
  localparam int LIM_W       = 7;
  localparam int CMD_W       = 3;
  localparam int PROD_W      = 2 * RAD_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int IN_DATA_W   = 136;
  localparam int OUT_DATA_W  = 112;
  localparam int MAX_ENT_DEF  = 1024;
  localparam int MAX_QRES_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_UPD = 3'd1,
    CMD_QRY = 3'd2,
    CMD_CHK = 3'd3,
    CMD_REF = 3'd4
  } cmd_e;

  // input beat, lowest field last
  typedef struct packed {
    logic [1:0]               pad;
    logic [LIM_W-1:0]         result_limit;
    logic                     exclude_team;
    logic [RAD_W-1:0]         radius;
    logic                     alive;
    logic [TEAM_W-1:0]        team;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
    logic [GEN_W-1:0]         generation;
    logic [SLOT_PW-1:0]       slot_index;
  } in_t;

  // result beat, lowest field last
  typedef struct packed {
    logic [4:0]               pad;
    logic                     full_res;
    logic                     found;
    logic                     out_alive;
    logic [TEAM_W-1:0]        out_team;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_x;
    logic                     handle_stale;
    logic                     handle_valid;
    logic [GEN_W-1:0]         out_generation;
    logic [SLOT_PW-1:0]       out_slot;
  } out_t;

  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic               alive;
    logic [TEAM_W-1:0]  team;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  typedef struct packed {
    logic mul;
    logic load;
    logic add;
  } sq_ctl_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
  endfunction

  function automatic entry_t make_entry(input in_t it, input logic [GEN_W-1:0] g);
    entry_t e;
    e.gen   = g;
    e.alive = it.alive;
    e.team  = it.team;
    e.z     = it.pos_z;
    e.y     = it.pos_y;
    e.x     = it.pos_x;
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/get_sqacc.sv @@
`default_nettype none

module get_sqacc (
  input  logic                        clk_i,
  input  get_pkg::sq_ctl_t            ctl_i,
  input  logic [get_pkg::RAD_W-1:0]   op_i,
  output logic [get_pkg::PROD_W-1:0]  prod_o,
  output logic [get_pkg::ACC_W-1:0]   acc_o
);
  import get_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= PROD_W'(op_i) * PROD_W'(op_i);
    end
    if (ctl_i.load) begin
      acc_q <= ACC_W'(prod_q);
    end else if (ctl_i.add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

@@ rtl/generational_entity_table_top.sv @@
// range query reads the used slots one at a time through the single entity read port;
// slots in the box, not of the excluded team, use the one shared squaring multiplier
// refresh scans every used slot; one item at a time, ready only when idle
// reset clears slot and free counts; entity and free stack memories are not cleared
`default_nettype none

module generational_entity_table_top #(
  parameter int MAX_ENTITIES      = get_pkg::MAX_ENT_DEF,
  parameter int MAX_QUERY_RESULTS = get_pkg::MAX_QRES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot_index, generation, pos_x, pos_y, pos_z, team, alive, radius,
  // exclude_team, result_limit, zero pad
  input  logic [get_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic [get_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_slot, out_generation, handle_valid, handle_stale, out_x, out_y, out_z,
  // out_team, out_alive, found, full_res, zero pad
  output logic [get_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import get_pkg::*;

  localparam int SLOT_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
  localparam int CMP_W  = (CNT_W > SLOT_PW) ? CNT_W : SLOT_PW;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_DISP = 16'h0002,
    ST_POP  = 16'h0004,
    ST_ADDG = 16'h0008,
    ST_CHK  = 16'h0010,
    ST_QR2  = 16'h0020,
    ST_QRD  = 16'h0040,
    ST_QDIF = 16'h0080,
    ST_QM0  = 16'h0100,
    ST_QM1  = 16'h0200,
    ST_QM2  = 16'h0400,
    ST_QM3  = 16'h0800,
    ST_QDEC = 16'h1000,
    ST_FRD  = 16'h2000,
    ST_FCHK = 16'h4000,
    ST_EMIT = 16'h8000
  } state_e;

  state_e            state_q, state_d;
  in_t               in_q, in_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  fc_q, fc_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [LIM_W-1:0]  cnt_q, cnt_d;
  logic [LIM_W-1:0]  lim_q, lim_d;
  logic [PROD_W-1:0] r2_q, r2_d;
  logic [RAD_W-1:0]  dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  out_t              stage_q, stage_d;
  logic              stage_last_q, stage_last_d;
  logic              pend_q, pend_d;
  out_t              out_q;
  logic              out_last_q;
  logic              out_valid_q, out_valid_d;

  logic              out_free;
  logic              out_load;
  out_t              out_load_data;
  logic              out_load_last;

  entry_t            ent_mem [MAX_ENTITIES];
  entry_t            ent_rd_q;
  logic              ent_we, ent_re;
  logic [SLOT_W-1:0] ent_waddr, ent_raddr;
  entry_t            ent_wdata;

  logic [SLOT_W-1:0] stk_mem [MAX_ENTITIES];
  logic [SLOT_W-1:0] stk_rd_q;
  logic              stk_we, stk_re;
  logic [SLOT_W-1:0] stk_waddr, stk_raddr, stk_wdata;

  sq_ctl_t           sq_ctl;
  logic [RAD_W-1:0]  sq_op;
  logic [PROD_W-1:0] sq_prod;
  logic [ACC_W-1:0]  sq_acc;

  logic [COORD_W-1:0] adx, ady, adz;
  logic [GEN_W-1:0]   g_cur;
  out_t               cur_res;

  get_sqacc u_sqacc (
    .clk_i  (clk_i),
    .ctl_i  (sq_ctl),
    .op_i   (sq_op),
    .prod_o (sq_prod),
    .acc_o  (sq_acc)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign adx      = abs_diff(ent_rd_q.x, in_q.pos_x);
  assign ady      = abs_diff(ent_rd_q.y, in_q.pos_y);
  assign adz      = abs_diff(ent_rd_q.z, in_q.pos_z);
  assign g_cur    = ent_rd_q.gen;

  always_comb begin
    cur_res                = '0;
    cur_res.out_slot       = SLOT_PW'(i_q);
    cur_res.out_generation = g_cur;
    cur_res.found          = 1'b1;
  end

  always_comb begin
    state_d       = state_q;
    in_d          = in_q;
    cmd_d         = cmd_q;
    used_d        = used_q;
    fc_d          = fc_q;
    i_d           = i_q;
    cnt_d         = cnt_q;
    lim_d         = lim_q;
    r2_d          = r2_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    dz_d          = dz_q;
    stage_d       = stage_q;
    stage_last_d  = stage_last_q;
    pend_d        = pend_q;
    out_load      = 1'b0;
    out_load_data = stage_q;
    out_load_last = stage_last_q;
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    ent_waddr     = '0;
    ent_raddr     = '0;
    ent_wdata     = '0;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_waddr     = '0;
    stk_raddr     = '0;
    stk_wdata     = '0;
    sq_ctl        = '0;
    sq_op         = '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          in_d    = in_t'(s_axis_tdata);
          cmd_d   = s_axis_tuser;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        stage_d      = '0;
        stage_last_d = 1'b1;
        case (cmd_q)
          CMD_ADD: begin
            if (fc_q != '0) begin
              stk_re    = 1'b1;
              stk_raddr = SLOT_W'(fc_q - 1'b1);
              fc_d      = fc_q - 1'b1;
              state_d   = ST_POP;
            end else if (CMP_W'(used_q) < CMP_W'(MAX_ENTITIES)) begin
              ent_we           = 1'b1;
              ent_waddr        = SLOT_W'(used_q);
              ent_wdata        = make_entry(in_q, '0);
              stage_d.out_slot = SLOT_PW'(used_q);
              used_d           = used_q + 1'b1;
              state_d          = ST_EMIT;
            end else begin
              stage_d.full_res = 1'b1;
              state_d          = ST_EMIT;
            end
          end
          CMD_UPD, CMD_CHK: begin
            stage_d.out_slot = in_q.slot_index;
            if (CMP_W'(in_q.slot_index) >= CMP_W'(used_q)) begin
              state_d = ST_EMIT;
            end else begin
              ent_re    = 1'b1;
              ent_raddr = SLOT_W'(in_q.slot_index);
              state_d   = ST_CHK;
            end
          end
          CMD_QRY: begin
            sq_ctl.mul = 1'b1;
            sq_op      = in_q.radius;
            i_d        = '0;
            cnt_d      = '0;
            pend_d     = 1'b0;
            if (in_q.result_limit == '0) begin
              lim_d = LIM_W'(1);
            end else if (in_q.result_limit > LIM_W'(MAX_QUERY_RESULTS)) begin
              lim_d = LIM_W'(MAX_QUERY_RESULTS);
            end else begin
              lim_d = in_q.result_limit;
            end
            state_d = ST_QR2;
          end
          CMD_REF: begin
            fc_d    = '0;
            i_d     = '0;
            state_d = ST_FRD;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_POP: begin
        ent_re    = 1'b1;
        ent_raddr = stk_rd_q;
        i_d       = CNT_W'(stk_rd_q);
        state_d   = ST_ADDG;
      end
      ST_ADDG: begin
        ent_we                 = 1'b1;
        ent_waddr              = i_q[SLOT_W-1:0];
        ent_wdata              = make_entry(in_q, g_cur + 1'b1);
        stage_d.out_slot       = SLOT_PW'(i_q);
        stage_d.out_generation = g_cur + 1'b1;
        state_d                = ST_EMIT;
      end
      ST_CHK: begin
        stage_d.out_generation = g_cur;
        stage_d.handle_valid   = (g_cur == in_q.generation);
        stage_d.handle_stale   = (g_cur > in_q.generation);
        if (cmd_q == CMD_UPD) begin
          if (g_cur == in_q.generation) begin
            ent_we    = 1'b1;
            ent_waddr = SLOT_W'(in_q.slot_index);
            ent_wdata = make_entry(in_q, g_cur);
          end
        end else begin
          stage_d.out_x     = ent_rd_q.x;
          stage_d.out_y     = ent_rd_q.y;
          stage_d.out_z     = ent_rd_q.z;
          stage_d.out_team  = ent_rd_q.team;
          stage_d.out_alive = ent_rd_q.alive;
        end
        state_d = ST_EMIT;
      end
      ST_QR2: begin
        r2_d    = sq_prod;
        state_d = ST_QRD;
      end
      ST_QRD: begin
        if (i_q < used_q) begin
          ent_re    = 1'b1;
          ent_raddr = i_q[SLOT_W-1:0];
          state_d   = ST_QDIF;
        end else begin
          if (!pend_q) begin
            stage_d = '0;
          end
          stage_last_d = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_QDIF: begin
        if (adx <= COORD_W'(in_q.radius) && ady <= COORD_W'(in_q.radius) &&
            adz <= COORD_W'(in_q.radius) &&
            !(in_q.exclude_team && ent_rd_q.team == in_q.team)) begin
          dx_d    = RAD_W'(adx);
          dy_d    = RAD_W'(ady);
          dz_d    = RAD_W'(adz);
          state_d = ST_QM0;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_QRD;
        end
      end
      ST_QM0: begin
        sq_ctl.mul = 1'b1;
        sq_op      = dx_q;
        state_d    = ST_QM1;
      end
      ST_QM1: begin
        sq_ctl.mul  = 1'b1;
        sq_ctl.load = 1'b1;
        sq_op       = dy_q;
        state_d     = ST_QM2;
      end
      ST_QM2: begin
        sq_ctl.mul = 1'b1;
        sq_ctl.add = 1'b1;
        sq_op      = dz_q;
        state_d    = ST_QM3;
      end
      ST_QM3: begin
        sq_ctl.add = 1'b1;
        state_d    = ST_QDEC;
      end
      ST_QDEC: begin
        if (sq_acc > ACC_W'(r2_q)) begin
          i_d     = i_q + 1'b1;
          state_d = ST_QRD;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            out_load      = 1'b1;
            out_load_data = stage_q;
            out_load_last = 1'b0;
          end
          stage_d = cur_res;
          pend_d  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          i_d     = i_q + 1'b1;
          if (cnt_q + 1'b1 == lim_q) begin
            stage_last_d = 1'b1;
            state_d      = ST_EMIT;
          end else begin
            stage_last_d = 1'b0;
            state_d      = ST_QRD;
          end
        end
      end
      ST_FRD: begin
        if (i_q < used_q) begin
          ent_re    = 1'b1;
          ent_raddr = i_q[SLOT_W-1:0];
          state_d   = ST_FCHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FCHK: begin
        if (!ent_rd_q.alive) begin
          stk_we    = 1'b1;
          stk_waddr = fc_q[SLOT_W-1:0];
          stk_wdata = i_q[SLOT_W-1:0];
          fc_d      = fc_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = ST_FRD;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = stage_q;
          out_load_last = stage_last_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      fc_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fc_q        <= fc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q         <= in_d;
    cmd_q        <= cmd_d;
    i_q          <= i_d;
    cnt_q        <= cnt_d;
    lim_q        <= lim_d;
    r2_q         <= r2_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    dz_q         <= dz_d;
    stage_q      <= stage_d;
    stage_last_q <= stage_last_d;
    if (out_load) begin
      out_q      <= out_load_data;
      out_last_q <= out_load_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  a_free_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= used_q)
    else $error("free count above used slots");

  a_used_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(used_q) <= CMP_W'(MAX_ENTITIES))
    else $error("used slots above capacity");

  a_push_mid_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_load_last) |-> (state_q == ST_QDEC && cnt_q < lim_q))
    else $error("non-final beat outside a query");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("result beat not loaded");

endmodule

`default_nettype wire

@@ tb/sv/entity_table_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none

module entity_table_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [get_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic [get_pkg::CMD_W-1:0]      s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [get_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                           m_tlast_i,
  output int                             err_cnt_o,
  output int                             pending_o
);
  import get_pkg::*;

  localparam int NSLOT = 1024;
  localparam int NQRES = 64;

  typedef struct packed {
    out_t d;
    logic last;
  } result_beat_t;

  logic signed [COORD_W-1:0] loc_x [NSLOT];
  logic signed [COORD_W-1:0] loc_y [NSLOT];
  logic signed [COORD_W-1:0] loc_z [NSLOT];
  logic [TEAM_W-1:0]         team_mem [NSLOT];
  logic                      alive_mem [NSLOT];
  logic [GEN_W-1:0]          slot_gen [NSLOT];
  int                        free_stack [NSLOT];
  int                        used_cnt;
  int                        free_cnt;
  result_beat_t              result_q [$];

  function automatic longint unsigned dist1(logic signed [COORD_W-1:0] a,
                                            logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  function automatic void store_entity(int s, in_t it);
    loc_x[s]     = it.pos_x;
    loc_y[s]     = it.pos_y;
    loc_z[s]     = it.pos_z;
    team_mem[s]  = it.team;
    alive_mem[s] = it.alive;
  endfunction

  function automatic void push_beat(out_t d, logic last);
    result_beat_t b;
    b.d    = d;
    b.last = last;
    result_q.push_back(b);
  endfunction

  function automatic void predict(in_t it, logic [CMD_W-1:0] c);
    out_t r;
    int s;
    int cnt;
    int lim;
    longint unsigned rad, dx, dy, dz;
    logic [GEN_W-1:0] g;
    r = '0;
    if (c == CMD_ADD) begin
      if (free_cnt > 0) begin
        free_cnt--;
        s = free_stack[free_cnt];
        slot_gen[s] = slot_gen[s] + 1'b1;
      end else if (used_cnt < NSLOT) begin
        s = used_cnt;
        used_cnt++;
        slot_gen[s] = '0;
      end else begin
        s = -1;
      end
      if (s < 0) begin
        r.full_res = 1'b1;
      end else begin
        store_entity(s, it);
        r.out_slot       = s[SLOT_PW-1:0];
        r.out_generation = slot_gen[s];
      end
      push_beat(r, 1'b1);
    end else if (c == CMD_UPD || c == CMD_CHK) begin
      s = it.slot_index;
      r.out_slot = it.slot_index;
      if (s < used_cnt) begin
        g = slot_gen[s];
        r.out_generation = g;
        r.handle_valid   = (g == it.generation);
        r.handle_stale   = (g > it.generation);
        if (c == CMD_UPD) begin
          if (r.handle_valid) store_entity(s, it);
        end else begin
          r.out_x     = loc_x[s];
          r.out_y     = loc_y[s];
          r.out_z     = loc_z[s];
          r.out_team  = team_mem[s];
          r.out_alive = alive_mem[s];
        end
      end
      push_beat(r, 1'b1);
    end else if (c == CMD_QRY) begin
      rad = it.radius;
      lim = it.result_limit;
      if (lim < 1) lim = 1;
      if (lim > NQRES) lim = NQRES;
      cnt = 0;
      for (int i = 0; i < used_cnt && cnt < lim; i++) begin
        dx = dist1(loc_x[i], it.pos_x);
        dy = dist1(loc_y[i], it.pos_y);
        dz = dist1(loc_z[i], it.pos_z);
        if (dx > rad || dy > rad || dz > rad) continue;
        if (dx * dx + dy * dy + dz * dz > rad * rad) continue;
        if (it.exclude_team && team_mem[i] == it.team) continue;
        r = '0;
        r.out_slot       = i[SLOT_PW-1:0];
        r.out_generation = slot_gen[i];
        r.found          = 1'b1;
        push_beat(r, 1'b0);
        cnt++;
      end
      if (cnt == 0) push_beat('0, 1'b1);
      else result_q[result_q.size()-1].last = 1'b1;
    end else if (c == CMD_REF) begin
      free_cnt = 0;
      for (int i = 0; i < used_cnt; i++) begin
        if (!alive_mem[i]) begin
          free_stack[free_cnt] = i;
          free_cnt++;
        end
      end
    end
  endfunction

  task automatic cmp(string nm, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", nm, e, a);
      err_cnt_o++;
    end
  endtask

  task automatic check_beat(out_t a, logic a_last);
    result_beat_t e;
    if (result_q.size() == 0) begin
      $error("unexpected result beat: slot %0d", a.out_slot);
      err_cnt_o++;
    end else begin
      e = result_q.pop_front();
      cmp("out_slot", e.d.out_slot, a.out_slot);
      cmp("out_generation", e.d.out_generation, a.out_generation);
      cmp("handle_valid", e.d.handle_valid, a.handle_valid);
      cmp("handle_stale", e.d.handle_stale, a.handle_stale);
      cmp("out_x", e.d.out_x, a.out_x);
      cmp("out_y", e.d.out_y, a.out_y);
      cmp("out_z", e.d.out_z, a.out_z);
      cmp("out_team", e.d.out_team, a.out_team);
      cmp("out_alive", e.d.out_alive, a.out_alive);
      cmp("found", e.d.found, a.found);
      cmp("full_res", e.d.full_res, a.full_res);
      cmp("last", e.last, a_last);
    end
  endtask

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
    used_cnt  = 0;
    free_cnt  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_cnt = 0;
      free_cnt = 0;
      result_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) predict(in_t'(s_tdata_i), s_tuser_i);
      if (m_tvalid_i && m_tready_i) check_beat(out_t'(m_tdata_i), m_tlast_i);
    end
    pending_o = result_q.size();
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import get_pkg::*;

  localparam longint CYCLE_LIMIT = 4_000_000;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid;
  logic s_axis_tready;
  in_t  s_tdata;
  logic [CMD_W-1:0] s_tuser;
  logic m_axis_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  int   err_cnt;
  int   pending;
  longint cycles;
  bit   calm;
  bit   fast;
  bit   long_hold;

  generational_entity_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  entity_table_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      n = (calm || fast) ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: return COORD_W'(32'sd8388607 - $urandom_range(0, 3));
      2: return COORD_W'(-32'sd8388608 + $urandom_range(0, 3));
      default: return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.pad          = '0;
    it.slot_index   = SLOT_PW'($urandom);
    it.generation   = GEN_W'($urandom);
    it.pos_x        = rand_coord();
    it.pos_y        = rand_coord();
    it.pos_z        = rand_coord();
    it.team         = TEAM_W'($urandom);
    it.alive        = 1'($urandom);
    it.exclude_team = 1'($urandom);
    it.result_limit = ($urandom_range(0, 3) == 0) ? LIM_W'($urandom) :
                      LIM_W'($urandom_range(0, 8));
    case ($urandom_range(0, 4))
      0: it.radius = RAD_W'($urandom);
      1: it.radius = '0;
      default: it.radius = RAD_W'($urandom_range(0, 6000));
    endcase
    return it;
  endfunction

  // mostly live handles, some stale or random
  function automatic void pick_handle(inout in_t it);
    int used;
    int s;
    logic [GEN_W-1:0] g;
    used = u_chk.used_cnt;
    if (used > 0 && $urandom_range(0, 9) < 8) begin
      s = $urandom_range(0, used - 1);
      g = u_chk.slot_gen[s];
      it.slot_index = s[SLOT_PW-1:0];
      case ($urandom_range(0, 7))
        6: it.generation = g - 1'b1;
        7: it.generation = GEN_W'($urandom);
        default: it.generation = g;
      endcase
    end
  endfunction

  function automatic void aim_near(inout in_t it);
    int s;
    if (u_chk.used_cnt > 0 && $urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, u_chk.used_cnt - 1);
      it.pos_x = u_chk.loc_x[s] + COORD_W'($signed($urandom_range(0, 200)) - 100);
      it.pos_y = u_chk.loc_y[s] + COORD_W'($signed($urandom_range(0, 200)) - 100);
      it.pos_z = u_chk.loc_z[s];
    end
  endfunction

  task automatic send(in_t it, logic [CMD_W-1:0] c);
    int gap;
    gap = (calm || fast) ? 0 : $urandom_range(0, 5);
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    s_tdata  <= it;
    s_tuser  <= c;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    in_t it;
    int p;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    calm     = 1'b0;
    fast     = 1'b0;
    long_hold = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one dead slot recycled a few times
    fast = 1'b1;
    @(negedge clk_i);
    it = rand_item();
    it.alive = 1'b0;
    send(it, CMD_ADD);
    for (int k = 0; k < 3; k++) begin
      @(negedge clk_i);
      send(rand_item(), CMD_REF);
      it = rand_item();
      it.alive = 1'b0;
      send(it, CMD_ADD);
    end
    fast = 1'b0;

    // directed
    @(negedge clk_i);
    it = rand_item();
    it.slot_index = '1;
    it.generation = '1;
    send(it, CMD_CHK);
    it = rand_item();
    it.slot_index = 10'd5;
    send(it, CMD_UPD);
    it = rand_item();
    it.pos_x = 24'sh7fffff; it.pos_y = 24'sh7fffff; it.pos_z = 24'sh7fffff;
    it.team = '1; it.alive = 1'b1;
    send(it, CMD_ADD);
    it.pos_x = 24'sh800000; it.pos_y = 24'sh800000; it.pos_z = 24'sh800000;
    it.team = '0;
    send(it, CMD_ADD);
    it.pos_x = '0; it.pos_y = '0; it.pos_z = '0;
    it.team = 4'd3; it.alive = 1'b0;
    send(it, CMD_ADD);
    @(negedge clk_i);
    it = rand_item();
    it.slot_index = '0;
    it.generation = '1;
    send(it, CMD_CHK);
    it.generation = '0;
    send(it, CMD_CHK);
    @(negedge clk_i);
    it.generation = u_chk.slot_gen[0];
    send(it, CMD_CHK);
    it.generation = it.generation + 16'd7;
    send(it, CMD_UPD);
    @(negedge clk_i);
    it = rand_item();
    it.slot_index = 10'd3;
    it.generation = u_chk.slot_gen[3];
    it.alive = 1'b1;
    send(it, CMD_UPD);
    it = rand_item();
    it.pos_x = 24'sh7fffff; it.pos_y = 24'sh7fffff; it.pos_z = 24'sh7fffff;
    it.radius = '0; it.result_limit = '0; it.exclude_team = 1'b0;
    send(it, CMD_QRY);
    it.pos_x = '0; it.pos_y = '0; it.pos_z = '0;
    it.radius = '1; it.result_limit = '1; it.exclude_team = 1'b1; it.team = '1;
    send(it, CMD_QRY);
    it.exclude_team = 1'b0; it.result_limit = 7'd1;
    send(it, CMD_QRY);
    it.pos_x = 24'sd100; it.radius = '0;
    send(it, CMD_QRY);
    send(rand_item(), 3'd5);
    send(rand_item(), 3'd6);
    send(rand_item(), 3'd7);
    send(rand_item(), CMD_REF);
    send(rand_item(), CMD_ADD);

    // random mix
    for (int k = 0; k < 340; k++) begin
      if (k % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      if (k == 120) long_hold = 1'b1;
      if (k == 240) drain();
      @(negedge clk_i);
      it = rand_item();
      p = $urandom_range(0, 99);
      if (u_chk.used_cnt == 0) p = 0;
      if (p < 30 && u_chk.used_cnt >= 100 && u_chk.free_cnt == 0) p = 40;
      if (p < 30) begin
        send(it, CMD_ADD);
      end else if (p < 50) begin
        pick_handle(it);
        send(it, CMD_UPD);
      end else if (p < 68) begin
        pick_handle(it);
        send(it, CMD_CHK);
      end else if (p < 83) begin
        aim_near(it);
        send(it, CMD_QRY);
      end else if (p < 91) begin
        send(it, CMD_REF);
      end else if (p < 95) begin
        send(it, CMD_CHK + CMD_W'($urandom_range(2, 4)));
      end else begin
        send(it, ($urandom_range(0, 1) == 0) ? CMD_UPD : CMD_CHK);
      end
    end

    // wide query over every slot, then a few closing items
    drain();
    calm = 1'b1;
    fast = 1'b1;
    @(negedge clk_i);
    it = rand_item();
    it.pos_x = '0; it.pos_y = '0; it.pos_z = '0;
    it.radius = 23'd20000; it.result_limit = 7'd64; it.exclude_team = 1'b0;
    send(it, CMD_QRY);
    @(negedge clk_i);
    it = rand_item();
    it.slot_index = '1;
    it.generation = u_chk.slot_gen[1023];
    it.alive = 1'b0;
    send(it, CMD_UPD);
    send(it, CMD_CHK);
    send(rand_item(), CMD_REF);
    send(rand_item(), CMD_ADD);
    send(rand_item(), CMD_ADD);

    drain();
    repeat (8000) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
